@@ rtl/bls_pkg.sv @@
// shared constants and types for the battery level smoother
package bls_pkg;

    // averaging window length in samples
    localparam int unsigned WINDOW     = 60;

    // field widths
    localparam int unsigned MV_W       = 16;
    localparam int unsigned CHG_W      = 8;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned CFG_IDX_W  = 2;

    // q7.8 level: percent times 256
    localparam int unsigned LVL_FRAC   = 8;
    localparam int unsigned PCT_FULL   = 100;
    localparam int unsigned LEVEL_FULL = PCT_FULL << LVL_FRAC;
    localparam int unsigned LVL_W      = 15;

    // ring pointer and running sum
    localparam int unsigned PTR_W      = $clog2(WINDOW);
    localparam int unsigned SUM_W      = $clog2(LEVEL_FULL * WINDOW + 1);
    localparam int unsigned ROUND_HALF = ((1 << LVL_FRAC) / 2) * WINDOW;

    // serial divider: quotient bits, divisor bits, dividend bits
    localparam int unsigned QUO_W      = LVL_W;
    localparam int unsigned DEN_W      = MV_W;
    localparam int unsigned NUM_W      = QUO_W + DEN_W;

    // stream payload widths, padded to whole bytes
    localparam int unsigned S_DATA_W   = ((MV_W + CHG_W + 7) / 8) * 8;
    localparam int unsigned M_DATA_W   = ((PCT_W + 2 + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_MV  = CFG_IDX_W'(0),
        CFG_EMPTY_MV = CFG_IDX_W'(1)
    } t_cfg_idx;

    // request to the serial divider
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

endpackage

@@ rtl/bls_ram.sv @@
// generic single-write, single-read ram with registered read data
module bls_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bls_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module bls_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bls_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [bls_pkg::QUO_W-1:0]   o_quot
);

    logic [bls_pkg::DEN_W-1:0]          r_rem;
    logic [bls_pkg::DEN_W-1:0]          r_den;
    logic [bls_pkg::QUO_W-1:0]          r_sh;   // dividend bits out, quotient bits in
    logic [$clog2(bls_pkg::QUO_W+1)-1:0] r_cnt;
    logic                               r_done;

    logic [bls_pkg::DEN_W:0] trial;
    logic [bls_pkg::DEN_W:0] diff;
    logic                    qbit;

    // dividend is known to give a quotient below 2**QUO_W, so the top part is below den
    assign trial = {r_rem, r_sh[bls_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem <= i_req.num[bls_pkg::NUM_W-1:bls_pkg::QUO_W];
                r_sh  <= i_req.num[bls_pkg::QUO_W-1:0];
                r_den <= i_req.den;
                r_cnt <= ($clog2(bls_pkg::QUO_W+1))'(bls_pkg::QUO_W);
            end else if (r_cnt != '0) begin
                r_rem <= qbit ? diff[bls_pkg::DEN_W-1:0] : trial[bls_pkg::DEN_W-1:0];
                r_sh  <= {r_sh[bls_pkg::QUO_W-2:0], qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ($clog2(bls_pkg::QUO_W+1))'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

@@ rtl/battery_level_smoother.sv @@
// top level: voltage to percent mapping with a moving-average smoother
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  s stream  | in        | i_s_tvalid / o_s_tready | voltage_mv, charger_state
//  m stream  | out       | o_m_tvalid / i_m_tready | level_percent, charging, discharging
//  cfg write | in        | i_cfg_valid/o_cfg_ready | register index, 16-bit value
//
//  one item at a time; an input transfer is worked through S_PREP, S_LEVEL (the level
//  divide, skipped when the level is clamped to full or empty), S_SUM, S_AVG0, S_AVG
//  and S_OUT, and the next input transfer can be taken in the cycle after the result is loaded
//  most of the work is done by the shared bit-serial divider, which yields 15 quotient
//  bits, once for the level and once more for the window average
//  reset (i_rst_n low at a clock edge) clears the control state and loads the
//  default full and empty voltages; the sample ring needs no clearing
//  a stalled result waits in the output register while the next item is taken
//  and worked on; only the final load waits for that register to drain
module battery_level_smoother (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // [15:0] voltage_mv, [23:16] charger_state
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [bls_pkg::S_DATA_W-1:0]       i_s_tdata,
    // [6:0] level_percent, [7] charging, [8] discharging, [15:9] zero
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [bls_pkg::M_DATA_W-1:0]       o_m_tdata,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bls_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bls_pkg::MV_W-1:0]           i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,     // waiting for an input transfer
        S_PREP,     // clamp checks, launch level divide
        S_LEVEL,    // level divide running
        S_SUM,      // window update
        S_AVG0,     // launch average divide
        S_AVG,      // average divide running
        S_OUT       // wait for the output register
    } t_state;

    t_state                        r_state;

    // configuration
    logic [bls_pkg::MV_W-1:0]      r_full_mv;
    logic [bls_pkg::MV_W-1:0]      r_empty_mv;

    // current item
    logic [bls_pkg::MV_W-1:0]      r_v;
    logic                          r_chg;
    logic [bls_pkg::LVL_W-1:0]     r_lvl;
    logic [bls_pkg::PCT_W-1:0]     r_pct;

    // window state
    logic [bls_pkg::LVL_W-1:0]     r_prime;
    logic [bls_pkg::PTR_W-1:0]     r_pos;
    logic [bls_pkg::SUM_W-1:0]     r_sum;
    logic                          r_primed;
    logic                          r_wrapped;

    // output register
    logic                          r_m_tvalid;
    logic [bls_pkg::M_DATA_W-1:0]  r_m_tdata;

    // datapath helpers
    logic                          s_xfer;
    logic                          v_at_full;
    logic                          v_at_empty;
    logic [bls_pkg::MV_W-1:0]      v_above;
    logic [bls_pkg::LVL_W-1:0]     ring_rdata;
    logic [bls_pkg::LVL_W-1:0]     old_lvl;
    logic [bls_pkg::SUM_W:0]       sum_upd;
    logic [bls_pkg::SUM_W:0]       sum_rnd;
    logic                          ring_we;
    bls_pkg::t_div_req             div_req;
    logic                          div_done;
    logic [bls_pkg::QUO_W-1:0]     div_quot;

    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // clamp cases: at or above full is 100 percent, ahead of the other checks; otherwise a
    // degenerate span or a voltage at or below empty is zero
    assign v_at_full  = (r_v >= r_full_mv);
    assign v_at_empty = (r_full_mv <= r_empty_mv) || (r_v <= r_empty_mv);
    assign v_above    = r_v - r_empty_mv;

    // value leaving the window: unwritten slots stand for the priming sample
    assign old_lvl = r_wrapped ? ring_rdata : r_prime;
    assign sum_upd = {1'b0, r_sum} - {{(bls_pkg::SUM_W+1-bls_pkg::LVL_W){1'b0}}, old_lvl}
                   + {{(bls_pkg::SUM_W+1-bls_pkg::LVL_W){1'b0}}, r_lvl};

    // round half up: add half a percent times the window, drop the fraction
    assign sum_rnd = {1'b0, r_sum} + (bls_pkg::SUM_W+1)'(bls_pkg::ROUND_HALF);

    // one divider serves both the level and the average
    always_comb begin
        div_req = '0;
        if (r_state == S_PREP && !v_at_full && !v_at_empty) begin
            div_req.start = 1'b1;
            div_req.num   = bls_pkg::NUM_W'(v_above) * bls_pkg::NUM_W'(bls_pkg::LEVEL_FULL);
            div_req.den   = r_full_mv - r_empty_mv;
        end else if (r_state == S_AVG0) begin
            div_req.start = 1'b1;
            div_req.num   = bls_pkg::NUM_W'(sum_rnd[bls_pkg::SUM_W:bls_pkg::LVL_FRAC]);
            div_req.den   = bls_pkg::DEN_W'(bls_pkg::WINDOW);
        end
    end

    bls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ring of past levels; the read port sits on the write pointer so the
    // outgoing sample is ready by the time the window is updated
    assign ring_we = (r_state == S_SUM) && r_primed;

    bls_ram #(
        .WIDTH (bls_pkg::LVL_W),
        .DEPTH (bls_pkg::WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_pos),
        .i_wdata (r_lvl),
        .i_raddr (r_pos),
        .o_rdata (ring_rdata)
    );

    // configuration registers; other indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_mv  <= bls_pkg::MV_W'(4200);
            r_empty_mv <= bls_pkg::MV_W'(3300);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == bls_pkg::CFG_FULL_MV) begin
                r_full_mv <= i_cfg_data;
            end
            if (i_cfg_index == bls_pkg::CFG_EMPTY_MV) begin
                r_empty_mv <= i_cfg_data;
            end
        end
    end

    // sequencer, window state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prime    <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_primed   <= 1'b0;
            r_wrapped  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            // in S_OUT the load below decides the output valid
            if (r_m_tvalid && i_m_tready && r_state != S_OUT) begin
                r_m_tvalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_v     <= i_s_tdata[bls_pkg::MV_W-1:0];
                        r_chg   <= (i_s_tdata[bls_pkg::MV_W +: bls_pkg::CHG_W] != '0);
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (v_at_full) begin
                        r_lvl   <= bls_pkg::LVL_W'(bls_pkg::LEVEL_FULL);
                        r_state <= S_SUM;
                    end else if (v_at_empty) begin
                        r_lvl   <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_LEVEL;
                    end
                end
                S_LEVEL: begin
                    if (div_done) begin
                        r_lvl   <= div_quot;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (!r_primed) begin
                        // first sample fills the whole window
                        r_prime   <= r_lvl;
                        r_sum     <= bls_pkg::SUM_W'(r_lvl * bls_pkg::WINDOW);
                        r_pos     <= '0;
                        r_wrapped <= 1'b0;
                        r_primed  <= 1'b1;
                    end else begin
                        r_sum <= sum_upd[bls_pkg::SUM_W-1:0];
                        if (r_pos == bls_pkg::PTR_W'(bls_pkg::WINDOW - 1)) begin
                            r_pos     <= '0;
                            r_wrapped <= 1'b1;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                    r_state <= S_AVG0;
                end
                S_AVG0: begin
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    if (div_done) begin
                        r_pct   <= div_quot[bls_pkg::PCT_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_tvalid || i_m_tready) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {(bls_pkg::M_DATA_W-bls_pkg::PCT_W-2)'(0),
                                       !r_chg, r_chg, r_pct};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

@@ rtl/bls_checker.sv @@
// port-level checks for the battery level smoother, bound to the top level
module bls_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          o_s_tready,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [bls_pkg::M_DATA_W-1:0]  o_m_tdata
);

    // a result never shows more than full scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[bls_pkg::PCT_W-1:0] <= bls_pkg::PCT_W'(bls_pkg::PCT_FULL)))
        else $error("level above full scale");

    // charging and discharging flags are complementary
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[bls_pkg::PCT_W] != o_m_tdata[bls_pkg::PCT_W+1]))
        else $error("charging and discharging flags agree");

    // one item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken twice in a row");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind battery_level_smoother bls_checker u_bls_checker (.*);

@@ sim/tb.sv @@
// testbench for battery_level_smoother: self-checking stream test with a level predictor
module tb;
    import bls_pkg::*;

    localparam logic [MV_W-1:0]      RESET_FULL_MV    = 16'd4200;
    localparam logic [MV_W-1:0]      RESET_EMPTY_MV   = 16'd3300;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B  = 2'd3;
    localparam int                   N_PHASES         = 10;
    localparam int                   ITEMS_PER_PHASE  = 172;
    localparam int                   LONG_HOLD_CYCLES = 600;
    localparam int                   QUIET_LIMIT      = 5000;
    localparam int                   TAIL_CYCLES      = 64;
    localparam int                   MAX_REPORTS      = 10;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic             charging;
        logic             discharging;
    } reading_t;

    // predicts the smoothed level and holds the readings still to come
    class charge_level_tracker;
        logic [MV_W-1:0]  full_mv  = RESET_FULL_MV;
        logic [MV_W-1:0]  empty_mv = RESET_EMPTY_MV;
        logic [LVL_W-1:0] ring [WINDOW];
        logic [LVL_W-1:0] first_level = '0;
        logic [SUM_W-1:0] window_sum  = '0;
        int unsigned      slot        = 0;
        bit               primed      = 1'b0;
        bit               wrapped     = 1'b0;
        reading_t         due_readings[$];
        int unsigned      mismatches  = 0;

        function void report(string msg);
            if (mismatches < MAX_REPORTS)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] val);
            case (t_cfg_idx'(idx))
                CFG_FULL_MV:  full_mv  = val;
                CFG_EMPTY_MV: empty_mv = val;
                default: ;
            endcase
        endfunction

        // q7.8 level, truncated
        function logic [LVL_W-1:0] level_of(logic [MV_W-1:0] mv);
            int unsigned scaled;
            if (mv >= full_mv)
                return LVL_W'(LEVEL_FULL);
            if (full_mv <= empty_mv || mv <= empty_mv)
                return '0;
            scaled = (32'(mv) - 32'(empty_mv)) * LEVEL_FULL;
            return LVL_W'(scaled / (32'(full_mv) - 32'(empty_mv)));
        endfunction

        function void take_sample(logic [MV_W-1:0] mv, logic [CHG_W-1:0] code);
            logic [LVL_W-1:0] lvl;
            logic [LVL_W-1:0] oldest;
            reading_t         r;
            lvl = level_of(mv);
            if (!primed) begin
                // first sample fills the whole window
                first_level = lvl;
                window_sum  = SUM_W'(lvl * WINDOW);
                slot        = 0;
                wrapped     = 1'b0;
                primed      = 1'b1;
            end else begin
                // slots not yet written stand for the first level
                oldest     = wrapped ? ring[slot] : first_level;
                window_sum = window_sum - oldest + lvl;
                ring[slot] = lvl;
                if (slot == WINDOW - 1) begin
                    slot    = 0;
                    wrapped = 1'b1;
                end else begin
                    slot = slot + 1;
                end
            end
            r.pct         = PCT_W'((32'(window_sum) + ROUND_HALF) / (WINDOW << LVL_FRAC));
            r.charging    = (code != '0);
            r.discharging = (code == '0);
            due_readings.push_back(r);
        endfunction

        function void check_reading(logic [M_DATA_W-1:0] word);
            reading_t want;
            if (due_readings.size() == 0) begin
                report($sformatf("result %0h with nothing outstanding", word));
                return;
            end
            want = due_readings.pop_front();
            if (word[PCT_W-1:0] !== want.pct)
                report($sformatf("level_percent expected %0d got %0d",
                                 want.pct, word[PCT_W-1:0]));
            if (word[PCT_W] !== want.charging)
                report($sformatf("charging expected %0b got %0b",
                                 want.charging, word[PCT_W]));
            if (word[PCT_W+1] !== want.discharging)
                report($sformatf("discharging expected %0b got %0b",
                                 want.discharging, word[PCT_W+1]));
            if (word[M_DATA_W-1:PCT_W+2] !== '0)
                report($sformatf("padding expected 0 got %0h", word[M_DATA_W-1:PCT_W+2]));
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [MV_W-1:0]       i_cfg_data  = '0;

    charge_level_tracker   sb = new();

    logic [MV_W-1:0]       cur_full  = RESET_FULL_MV;
    logic [MV_W-1:0]       cur_empty = RESET_EMPTY_MV;
    int                    walk_mv   = 3750;
    int                    s_gap_pct = 0;
    int                    m_stall_pct = 0;
    int                    m_stall_left = 0;
    logic                  long_hold = 1'b0;
    logic                  long_hold_done = 1'b0;
    int                    quiet_cycles = 0;

    battery_level_smoother u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // mostly short pauses, now and then a long one
    function automatic int pick_pause(int pct);
        if (int'($urandom_range(99)) >= pct)
            return 0;
        return ($urandom_range(9) == 0) ? int'($urandom_range(80, 20))
                                        : int'($urandom_range(3, 1));
    endfunction

    function automatic logic [MV_W-1:0] pick_mv();
        int lo;
        int hi;
        int step;
        int r;
        lo   = (cur_full < cur_empty) ? int'(cur_full) : int'(cur_empty);
        hi   = (cur_full < cur_empty) ? int'(cur_empty) : int'(cur_full);
        step = (hi - lo) / 20 + 1;
        r    = int'($urandom_range(99));
        if (r < 10)
            return MV_W'($urandom);
        if (r < 20)
            return cur_full + MV_W'($urandom_range(4)) - 16'd2;
        if (r < 30)
            return cur_empty + MV_W'($urandom_range(4)) - 16'd2;
        // slow drift between the two thresholds so the average moves around
        if (r < 33)
            walk_mv = lo + int'($urandom_range(hi - lo));
        else
            walk_mv = walk_mv + int'($urandom_range(2 * step)) - step;
        if (walk_mv < lo)
            walk_mv = lo;
        if (walk_mv > hi)
            walk_mv = hi;
        return MV_W'(walk_mv);
    endfunction

    function automatic logic [CHG_W-1:0] pick_code();
        if ($urandom_range(99) < 35)
            return '0;
        return CHG_W'($urandom);
    endfunction

    // sink side: random stalls plus one long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready   <= 1'b0;
            m_stall_left <= 0;
        end else if (long_hold && !long_hold_done) begin
            i_m_tready     <= 1'b0;
            m_stall_left   <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else if (m_stall_left > 0) begin
            i_m_tready   <= 1'b0;
            m_stall_left <= m_stall_left - 1;
        end else begin
            i_m_tready   <= 1'b1;
            m_stall_left <= pick_pause(m_stall_pct);
        end
    end

    // every transfer goes to the tracker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready)
                sb.take_sample(i_s_tdata[MV_W-1:0], i_s_tdata[MV_W+CHG_W-1:MV_W]);
            if (o_m_tvalid && i_m_tready)
                sb.check_reading(o_m_tdata);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [MV_W-1:0] mv, input logic [CHG_W-1:0] code);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {code, mv};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.due_readings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic end_phase();
        i_s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // only called with nothing in flight; spare indexes get junk that must be ignored
    task automatic set_range(input logic [MV_W-1:0] full, input logic [MV_W-1:0] empty);
        cfg_write(CFG_IDX_SPARE_A, MV_W'($urandom));
        cfg_write(CFG_FULL_MV, full);
        cfg_write(CFG_IDX_SPARE_B, MV_W'($urandom));
        cfg_write(CFG_EMPTY_MV, empty);
        i_cfg_valid <= 1'b0;
        cur_full  = full;
        cur_empty = empty;
    endtask

    task automatic run_items(input int n, input int pause_at);
        int gap;
        for (int k = 0; k < n; k++) begin
            send_item(pick_mv(), pick_code());
            if (k == pause_at) begin
                end_phase();
            end else begin
                gap = pick_pause(s_gap_pct);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        logic [MV_W-1:0] full;
        logic [MV_W-1:0] empty;
        int              sel;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds; the first transfer primes the window
        send_item(16'd3750, 8'h00);
        send_item(16'd0, 8'hFF);
        send_item(16'd65535, 8'h01);
        send_item(16'd3300, 8'h80);
        send_item(16'd3301, 8'h00);
        send_item(16'd4199, 8'h7F);
        send_item(16'd4200, 8'h00);
        send_item(16'd4201, 8'hFE);
        send_item(16'd3299, 8'h01);
        end_phase();

        // widest span
        set_range(16'hFFFF, 16'h0000);
        send_item(16'hFFFF, 8'h00);
        send_item(16'hFFFE, 8'hFF);
        send_item(16'h0000, 8'h00);
        send_item(16'h5555, 8'hAA);
        send_item(16'hAAAA, 8'h55);
        end_phase();

        // full not above empty: no divide, only full or nothing
        set_range(16'd0, 16'd0);
        send_item(16'd0, 8'h00);
        send_item(16'd12345, 8'h01);
        end_phase();
        set_range(16'd100, 16'hFFFF);
        send_item(16'd99, 8'h00);
        send_item(16'd100, 8'h01);
        send_item(16'hFFFF, 8'h00);
        end_phase();
        set_range(16'd5000, 16'd5000);
        send_item(16'd4999, 8'h00);
        send_item(16'd5000, 8'h01);
        end_phase();

        // span of one millivolt
        set_range(16'd1, 16'd0);
        send_item(16'd0, 8'h00);
        send_item(16'd1, 8'h01);
        end_phase();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            sel = int'($urandom_range(9));
            if (sel < 6) begin
                empty = MV_W'($urandom_range(3600, 2500));
                full  = empty + MV_W'($urandom_range(1500, 50));
            end else if (sel == 6) begin
                full  = MV_W'($urandom);
                empty = MV_W'($urandom);
            end else if (sel == 7) begin
                full  = MV_W'($urandom);
                empty = full;
            end else if (sel == 8) begin
                full  = 16'hFFFF;
                empty = 16'h0000;
            end else begin
                empty = MV_W'($urandom_range(65535, 1));
                full  = MV_W'($urandom_range(int'(empty) - 1, 0));
            end
            set_range(full, empty);
            walk_mv = (int'(full) + int'(empty)) / 2;

            // first phase runs flat out, the third holds the sink off for a long stretch
            s_gap_pct    = (ph == 0 || ph == 2) ? 0 : 10 * int'($urandom_range(5));
            m_stall_pct <= (ph == 0) ? 0 : 10 * int'($urandom_range(5));
            if (ph == 2)
                long_hold <= 1'b1;
            run_items(ITEMS_PER_PHASE, (ph == 4) ? ITEMS_PER_PHASE / 2 : -1);
            end_phase();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.due_readings.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
